>>> rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the car-following speed step core.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADWAY_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_REACT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_PROB    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAWDLE_SIGMA   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH    = 3'd6;

    localparam logic [11:0] RST_ACCEL_MAX    = 12'd666;
    localparam logic [11:0] RST_DECEL_MAX    = 12'd1152;
    localparam logic [11:0] RST_HEADWAY_TIME = 12'd256;
    localparam logic [11:0] RST_LEADER_REACT = 12'd77;
    localparam logic [15:0] RST_ACTION_PROB  = 16'd32768;
    localparam logic [11:0] RST_DAWDLE_SIGMA = 12'd128;
    localparam logic [11:0] RST_STEP_LENGTH  = 12'd256;

    localparam logic OP_FOLLOW = 1'b0;
    localparam logic OP_STOP   = 1'b1;

    // gap below 0.01 m
    localparam logic signed [19:0] GAP_MIN_RAW = 20'sd3;

    localparam int SQ_STEPS = 25;
    localparam int PD_STEPS = 36;
    localparam int AS_STEPS = 33;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        own_speed;
        logic signed [19:0] gap_dist;
        logic [15:0]        leader_speed;
        logic signed [15:0] prev_accel;
        logic [15:0]        rand_action;
        logic signed [15:0] rand_noise;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        next_speed;
        logic signed [15:0] applied_accel;
        logic               action_taken;
    } t_out_word;

endpackage

`default_nettype wire

>>> rtl/car_following_speed_step_core.sv
// ----------------------------------------------------------------------------
// car_following_speed_step_core
// Krauss-style next-speed step with action points, fixed point, pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle while the output is not stalled. The bit-per-stage
//  square root (25 stages) is followed by the safe-acceleration divider
//  (33 stages), with the preferred-acceleration divider alongside.
//  Synchronous active-low reset clears the stage valid bits and loads the config defaults.
//  A stalled output freezes the whole pipeline; o_in_ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

module car_following_speed_step_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cfs_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cfs_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cfs_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import cfs_pkg::*;

    localparam int NK = SQ_STEPS + 1 + AS_STEPS;
    localparam logic [36:0] PD_SAT = 37'h10_0000_0000;

    typedef struct packed {
        logic               zero;
        logic               stop;
        logic               rtest;
        logic [15:0]        v;
        logic signed [15:0] aold;
        logic signed [21:0] noise;
        logic [23:0]        hd;
        logic [49:0]        sq_x;
        logic [25:0]        sq_rem;
        logic [24:0]        sq_root;
        logic [37:0]        den;
        logic [35:0]        pd_n;
        logic [37:0]        pd_rem;
        logic [35:0]        pd_q;
        logic               pd_sat;
        logic               pd_neg;
        logic               pd_zero;
        logic signed [25:0] vsafe;
        logic [32:0]        as_n;
        logic [12:0]        as_rem;
        logic [32:0]        as_q;
        logic               as_neg;
    } t_ctx;

    // config
    logic [11:0] r_accel_max, r_decel_max, r_headway, r_leader_react;
    logic [11:0] r_dawdle_sigma, r_step_length;
    logic [15:0] r_action_prob;
    logic [11:0] w_tau, w_ts;

    assign o_cfg_ready = 1'b1;
    assign w_tau = (r_headway == '0) ? 12'd1 : r_headway;
    assign w_ts  = (r_step_length == '0) ? 12'd1 : r_step_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_max    <= RST_ACCEL_MAX;
            r_decel_max    <= RST_DECEL_MAX;
            r_headway      <= RST_HEADWAY_TIME;
            r_leader_react <= RST_LEADER_REACT;
            r_action_prob  <= RST_ACTION_PROB;
            r_dawdle_sigma <= RST_DAWDLE_SIGMA;
            r_step_length  <= RST_STEP_LENGTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACCEL_MAX:    r_accel_max    <= i_cfg_data[11:0];
                CFG_DECEL_MAX:    r_decel_max    <= i_cfg_data[11:0];
                CFG_HEADWAY_TIME: r_headway      <= i_cfg_data[11:0];
                CFG_LEADER_REACT: r_leader_react <= i_cfg_data[11:0];
                CFG_ACTION_PROB:  r_action_prob  <= i_cfg_data;
                CFG_DAWDLE_SIGMA: r_dawdle_sigma <= i_cfg_data[11:0];
                CFG_STEP_LENGTH:  r_step_length  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;
    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;

    // ---------------- stage 1: capture, headway products
    logic               r1_valid, r1_zero, r1_stop;
    logic [15:0]        r1_v, r1_vp, r1_ra;
    logic signed [19:0] r1_g;
    logic signed [15:0] r1_aold, r1_rn;
    logic [23:0]        r1_hd, r1_dectau;
    logic               w1_stop;
    logic [15:0]        w1_vp;

    assign w1_stop = i_in_word.opcode == OP_STOP;
    assign w1_vp   = w1_stop ? 16'd0 : i_in_word.leader_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_stop   <= w1_stop;
            r1_zero   <= (i_in_word.gap_dist < GAP_MIN_RAW) && (w1_vp == 16'd0);
            r1_v      <= i_in_word.own_speed;
            r1_vp     <= w1_vp;
            r1_g      <= i_in_word.gap_dist;
            r1_aold   <= i_in_word.prev_accel;
            r1_ra     <= i_in_word.rand_action;
            r1_rn     <= i_in_word.rand_noise;
            r1_hd     <= 24'(r_decel_max) * 24'(w1_stop ? w_tau : r_leader_react);
            r1_dectau <= 24'(r_decel_max) * 24'(w_tau);
        end
    end

    // ---------------- stage 2: squares and cross products
    logic               r2_valid, r2_zero, r2_stop, r2_rtest;
    logic [15:0]        r2_v;
    logic signed [19:0] r2_g;
    logic signed [15:0] r2_aold;
    logic [23:0]        r2_hd;
    logic [47:0]        r2_hd2;
    logic [31:0]        r2_vp2;
    logic signed [32:0] r2_dg;
    logic signed [31:0] r2_pb;
    logic [25:0]        r2_dent;
    logic signed [28:0] r2_nprod;
    logic signed [18:0] w2_dv;

    assign w2_dv = $signed({3'b0, r1_vp}) - $signed({2'b0, r1_v, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_zero  <= r1_zero;
            r2_stop  <= r1_stop;
            r2_v     <= r1_v;
            r2_g     <= r1_g;
            r2_aold  <= r1_aold;
            r2_hd    <= r1_hd;
            r2_hd2   <= 48'(r1_hd) * 48'(r1_hd);
            r2_vp2   <= 32'(r1_vp) * 32'(r1_vp);
            r2_dg    <= $signed({1'b0, r_decel_max}) * r1_g;
            r2_pb    <= w2_dv * $signed({1'b0, w_tau});
            r2_dent  <= 26'({r1_v, 8'b0}) + 26'(r1_dectau);
            r2_rtest <= 28'({r1_ra, 8'b0}) <= (28'(r_action_prob) * 28'(w_ts));
            r2_nprod <= $signed({1'b0, r_dawdle_sigma}) * r1_rn;
        end
    end

    // ---------------- stage 3: radicand, numerator term, denominator
    logic               r3_valid, r3_zero, r3_stop, r3_rtest;
    logic [15:0]        r3_v;
    logic signed [15:0] r3_aold;
    logic [23:0]        r3_hd;
    logic [49:0]        r3_rad;
    logic signed [32:0] r3_b;
    logic [37:0]        r3_den;
    logic signed [21:0] r3_noise;
    logic signed [50:0] w3_rad;
    logic signed [28:0] w3_nr;

    assign w3_rad = $signed({3'b0, r2_hd2}) + $signed({3'b0, r2_vp2, 16'b0})
                  + (51'(r2_dg) <<< 17);
    assign w3_nr  = r2_nprod + (r2_nprod[28] ? 29'sd127 : 29'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_zero  <= r2_zero;
            r3_stop  <= r2_stop;
            r3_rtest <= r2_rtest;
            r3_v     <= r2_v;
            r3_aold  <= r2_aold;
            r3_hd    <= r2_hd;
            r3_rad   <= w3_rad[50] ? 50'd0 : w3_rad[49:0];
            r3_b     <= (33'(r2_g) <<< 8) + 33'(r2_pb);
            r3_den   <= 38'(r2_dent) * 38'(w_tau);
            r3_noise <= 22'(w3_nr >>> 7);
        end
    end

    // ---------------- stage 4: preferred-acceleration numerator
    logic               r4_valid, r4_zero, r4_stop, r4_rtest;
    logic [15:0]        r4_v;
    logic signed [15:0] r4_aold;
    logic [23:0]        r4_hd;
    logic [49:0]        r4_rad;
    logic [37:0]        r4_den;
    logic signed [21:0] r4_noise;
    logic signed [45:0] r4_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_zero  <= r3_zero;
            r4_stop  <= r3_stop;
            r4_rtest <= r3_rtest;
            r4_v     <= r3_v;
            r4_aold  <= r3_aold;
            r4_hd    <= r3_hd;
            r4_rad   <= r3_rad;
            r4_den   <= r3_den;
            r4_noise <= r3_noise;
            r4_num   <= $signed({1'b0, r_decel_max}) * r3_b;
        end
    end

    // ---------------- stage 5: divider and root setup
    logic        r5_valid;
    t_ctx        r5_ctx;
    t_ctx        n5_ctx;
    logic [45:0] w5_mag;
    logic        w5_ovf;

    assign w5_mag = r4_num[45] ? 46'(-r4_num) : 46'(r4_num);
    assign w5_ovf = 38'(w5_mag[41:20]) >= r4_den;

    always_comb begin
        n5_ctx         = '0;
        n5_ctx.zero    = r4_zero;
        n5_ctx.stop    = r4_stop;
        n5_ctx.rtest   = r4_rtest;
        n5_ctx.v       = r4_v;
        n5_ctx.aold    = r4_aold;
        n5_ctx.noise   = r4_noise;
        n5_ctx.hd      = r4_hd;
        n5_ctx.sq_x    = r4_rad;
        n5_ctx.den     = r4_den;
        n5_ctx.pd_n    = {w5_mag[19:0], 16'b0};
        n5_ctx.pd_rem  = w5_ovf ? 38'd0 : 38'(w5_mag[41:20]);
        n5_ctx.pd_sat  = w5_ovf;
        n5_ctx.pd_neg  = r4_num[45];
        n5_ctx.pd_zero = r4_den == 38'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ctx <= n5_ctx;
        end
    end

    // ---------------- iterative stages: root, then safe-accel divide;
    // preferred-accel divide runs in the first stages alongside
    logic r_cv  [NK];
    t_ctx r_ctx [NK];
    t_ctx n_ctx [NK];

    for (genvar k = 0; k < NK; k++) begin : g_stage
        t_ctx               c_in;
        logic               v_in;
        logic [27:0]        sq_r2, sq_tr;
        logic [37:0]        pd_r2;
        logic [12:0]        as_r2;
        logic signed [25:0] vs;
        logic signed [26:0] as_d;
        logic [26:0]        as_m;

        if (k == 0) begin : g_first
            assign c_in = r5_ctx;
            assign v_in = r5_valid;
        end else begin : g_next
            assign c_in = r_ctx[k-1];
            assign v_in = r_cv[k-1];
        end

        always_comb begin
            n_ctx[k] = c_in;
            sq_r2 = {c_in.sq_rem, c_in.sq_x[49:48]};
            sq_tr = {1'b0, c_in.sq_root, 2'b01};
            pd_r2 = {c_in.pd_rem[36:0], c_in.pd_n[35]};
            as_r2 = {c_in.as_rem[11:0], c_in.as_n[32]};
            vs    = $signed({1'b0, c_in.sq_root}) - $signed({2'b0, c_in.hd});
            as_d  = 27'(vs) - $signed({3'b0, c_in.v, 8'b0});
            as_m  = as_d[26] ? 27'(-as_d) : 27'(as_d);
            if (k < SQ_STEPS) begin
                n_ctx[k].sq_x = {c_in.sq_x[47:0], 2'b00};
                if (sq_r2 >= sq_tr) begin
                    n_ctx[k].sq_rem  = 26'(sq_r2 - sq_tr);
                    n_ctx[k].sq_root = {c_in.sq_root[23:0], 1'b1};
                end else begin
                    n_ctx[k].sq_rem  = 26'(sq_r2);
                    n_ctx[k].sq_root = {c_in.sq_root[23:0], 1'b0};
                end
            end
            if (k < PD_STEPS) begin
                n_ctx[k].pd_n = {c_in.pd_n[34:0], 1'b0};
                if (pd_r2 >= c_in.den) begin
                    n_ctx[k].pd_rem = pd_r2 - c_in.den;
                    n_ctx[k].pd_q   = {c_in.pd_q[34:0], 1'b1};
                end else begin
                    n_ctx[k].pd_rem = pd_r2;
                    n_ctx[k].pd_q   = {c_in.pd_q[34:0], 1'b0};
                end
            end
            if (k == SQ_STEPS) begin
                n_ctx[k].vsafe  = vs;
                n_ctx[k].as_n   = {as_m[24:0], 8'b0};
                n_ctx[k].as_neg = as_d[26];
                n_ctx[k].as_rem = '0;
                n_ctx[k].as_q   = '0;
            end
            if (k > SQ_STEPS) begin
                n_ctx[k].as_n = {c_in.as_n[31:0], 1'b0};
                if (as_r2 >= {1'b0, w_ts}) begin
                    n_ctx[k].as_rem = as_r2 - {1'b0, w_ts};
                    n_ctx[k].as_q   = {c_in.as_q[31:0], 1'b1};
                end else begin
                    n_ctx[k].as_rem = as_r2;
                    n_ctx[k].as_q   = {c_in.as_q[31:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else if (w_en) begin
                r_cv[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
    end

    // ---------------- stage 6: select acceleration
    t_ctx               w6_c;
    logic signed [37:0] w6_asafe, w6_q, w6_hi, w6_lo, w6_cq, w6_aold, w6_p0, w6_p;
    logic [36:0]        w6_qm;
    logic               w6_act;
    logic signed [25:0] w6_base;

    assign w6_c     = r_ctx[NK-1];
    assign w6_asafe = w6_c.as_neg ? -$signed({5'b0, w6_c.as_q}) : $signed({5'b0, w6_c.as_q});
    assign w6_qm    = w6_c.pd_sat ? PD_SAT : {1'b0, w6_c.pd_q};
    assign w6_hi    = $signed({18'b0, r_accel_max, 8'b0});
    assign w6_lo    = -$signed({18'b0, r_decel_max, 8'b0});
    assign w6_aold  = 38'(w6_c.aold) <<< 8;

    always_comb begin
        if (w6_c.pd_zero) begin
            w6_q = '0;
        end else if (w6_c.pd_neg) begin
            w6_q = -$signed({1'b0, w6_qm});
        end else begin
            w6_q = $signed({1'b0, w6_qm});
        end
        if (w6_q > w6_hi) begin
            w6_cq = w6_hi;
        end else if (w6_q < w6_lo) begin
            w6_cq = w6_lo;
        end else begin
            w6_cq = w6_q;
        end
        if (w6_c.stop) begin
            w6_act  = 1'b1;
            w6_p0   = w6_cq;
            w6_p    = (w6_q <= w6_asafe) ? w6_cq : w6_asafe;
            w6_base = w6_c.vsafe;
        end else begin
            w6_act  = (w6_aold <= w6_asafe) && w6_c.rtest;
            w6_p0   = w6_act ? (w6_cq + 38'(w6_c.noise)) : w6_aold;
            w6_p    = (w6_p0 > w6_asafe) ? w6_asafe : w6_p0;
            w6_base = $signed({2'b0, w6_c.v, 8'b0});
        end
    end

    logic               r6_valid, r6_zero, r6_act;
    logic signed [37:0] r6_p;
    logic signed [25:0] r6_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= r_cv[NK-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_zero <= w6_c.zero;
            r6_act  <= w6_act;
            r6_p    <= w6_p;
            r6_base <= w6_base;
        end
    end

    // ---------------- stage 7: acceleration times step
    logic               r7_valid, r7_zero, r7_act;
    logic signed [37:0] r7_p;
    logic signed [25:0] r7_base;
    logic signed [50:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_zero <= r6_zero;
            r7_act  <= r6_act;
            r7_p    <= r6_p;
            r7_base <= r6_base;
            r7_prod <= r6_p * $signed({1'b0, w_ts});
        end
    end

    // ---------------- stage 8: speed update, saturation, output word
    logic signed [50:0] w8_step, w8_nxt, w8_s;
    logic signed [37:0] w8_a;
    t_out_word          w8_word;
    t_out_word          r_out_word;

    assign w8_step = (r7_prod + (r7_prod[50] ? 51'sd255 : 51'sd0)) >>> 8;
    assign w8_nxt  = 51'(r7_base) + w8_step;
    assign w8_s    = w8_nxt >>> 8;
    assign w8_a    = (r7_p + (r7_p[37] ? 38'sd255 : 38'sd0)) >>> 8;

    always_comb begin
        w8_word = '0;
        if (!r7_zero) begin
            if (w8_nxt[50]) begin
                w8_word.next_speed = 16'd0;
            end else if (w8_s > 51'sd65535) begin
                w8_word.next_speed = 16'hFFFF;
            end else begin
                w8_word.next_speed = w8_s[15:0];
            end
            if (w8_a > 38'sd32767) begin
                w8_word.applied_accel = 16'sh7FFF;
            end else if (w8_a < -38'sd32768) begin
                w8_word.applied_accel = 16'sh8000;
            end else begin
                w8_word.applied_accel = w8_a[15:0];
            end
            w8_word.action_taken = r7_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_word <= w8_word;
        end
    end

    assign o_out_word = r_out_word;

endmodule

`default_nettype wire

>>> rtl/cfs_checker.sv
// ----------------------------------------------------------------------------
// cfs_checker
// Port-level checks of the car-following speed step core, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_in_ready,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire cfs_pkg::t_out_word            o_out_word,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          o_cfg_ready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // input taken whenever the output register can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input blocked with output free");

    // pipeline frozen while the result waits
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipeline stalled");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // config always writable
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind car_following_speed_step_core cfs_checker u_cfs_checker (.*);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the car-following speed step core. Each accepted input word queues its
// result, from a local fixed-point model or as given for typed rows; output
// words are compared field by field in order. Directed rows come first, then
// random words under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------

module tb;
    import cfs_pkg::*;

    localparam int LIMIT = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    car_following_speed_step_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    logic [15:0] cfg_shadow [7];
    t_out_word   speed_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 0;
    bit          stall_req = 0;
    int          hold = 0;
    int          out_wait = 0;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint pref_acc(longint dec, longint tau, longint v, longint vp,
                                        longint g);
        longint b = g * 256 + (vp - 2 * v) * tau;
        longint den = tau * (v * 256 + dec * tau);
        if (den == 0) return 0;
        return (dec * b * 65536) / den;
    endfunction

    function automatic t_out_word predict_speed(t_in_word w);
        t_out_word o = '0;
        longint acc = cfg_shadow[CFG_ACCEL_MAX];
        longint dec = cfg_shadow[CFG_DECEL_MAX];
        longint tau = cfg_shadow[CFG_HEADWAY_TIME] ? cfg_shadow[CFG_HEADWAY_TIME] : 1;
        longint tl  = cfg_shadow[CFG_LEADER_REACT];
        longint unsigned prob = cfg_shadow[CFG_ACTION_PROB];
        longint sig = cfg_shadow[CFG_DAWDLE_SIGMA];
        longint ts  = cfg_shadow[CFG_STEP_LENGTH] ? cfg_shadow[CFG_STEP_LENGTH] : 1;
        bit stop = (w.opcode == OP_STOP);
        longint v = w.own_speed;
        longint g = w.gap_dist;
        longint vp = stop ? 0 : longint'(w.leader_speed);
        longint aold = w.prev_accel;
        longint unsigned ra = w.rand_action;
        longint rn = w.rand_noise;
        longint hd, rad, vsafe, asafe, ap, base, nxt, aout;
        bit act = 0;
        if (g < 3 && (stop || vp == 0)) return o;
        hd = dec * (stop ? tau : tl);
        rad = hd * hd + vp * vp * 65536 + 2 * dec * g * 65536;
        if (rad < 0) rad = 0;
        vsafe = longint'(isqrt(rad)) - hd;
        asafe = ((vsafe - v * 256) * 256) / ts;
        if (stop) begin
            act = 1;
            ap = pref_acc(dec, tau, v, 0, g);
            if (ap <= asafe) begin
                if (ap > acc * 256) ap = acc * 256;
                if (ap < -dec * 256) ap = -dec * 256;
            end else begin
                ap = asafe;
            end
            base = vsafe;
        end else begin
            ap = aold * 256;
            if (ap <= asafe && ra * 256 <= prob * longint'(ts)) begin
                act = 1;
                ap = pref_acc(dec, tau, v, vp, g);
                if (ap > acc * 256) ap = acc * 256;
                if (ap < -dec * 256) ap = -dec * 256;
                ap += (sig * rn) / 128;
            end
            if (ap > asafe) ap = asafe;
            base = v * 256;
        end
        nxt = base + (ap * ts) / 256;
        if (nxt < 0) nxt = 0;
        nxt /= 256;
        if (nxt > 65535) nxt = 65535;
        aout = ap / 256;
        if (aout > 32767) aout = 32767;
        if (aout < -32768) aout = -32768;
        o.next_speed = nxt[15:0];
        o.applied_accel = aout[15:0];
        o.action_taken = act;
        return o;
    endfunction

    task automatic send_word(t_in_word w, bit typed, t_out_word res);
        int gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        speed_q.push_back(typed ? res : predict_speed(w));
    endtask

    // leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_shadow[idx] = (idx == CFG_ACTION_PROB) ? val : {4'd0, val[11:0]};
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (speed_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        w.opcode = 1'($urandom_range(0, 1));
        w.own_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 12000));
        case ($urandom_range(0, 4))
            0: w.gap_dist = 20'($urandom);
            1: w.gap_dist = 20'($urandom_range(0, 8) - 4);
            default: w.gap_dist = 20'($urandom_range(0, 40000));
        endcase
        w.leader_speed = ($urandom_range(0, 7) == 0) ? 16'd0 :
                         ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
        w.prev_accel = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 2000) - 1000);
        w.rand_action = 16'($urandom);
        w.rand_noise = 16'($urandom);
        return w;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (stall_req) begin
                hold = 600;
                stall_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                if (o_out_valid && i_out_ready) out_wait = calm ? 0 : $urandom_range(0, 14);
                if (out_wait > 0) begin
                    out_wait--;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (speed_q.size() == 0) begin
                $display("%0t unexpected word %h", $time, o_out_word);
                errors++;
            end else begin
                e = speed_q.pop_front();
                if (o_out_word.next_speed !== e.next_speed) begin
                    $display("%0t next_speed exp %0d got %0d", $time, e.next_speed,
                             o_out_word.next_speed);
                    errors++;
                end
                if (o_out_word.applied_accel !== e.applied_accel) begin
                    $display("%0t applied_accel exp %0d got %0d", $time,
                             $signed(e.applied_accel), $signed(o_out_word.applied_accel));
                    errors++;
                end
                if (o_out_word.action_taken !== e.action_taken) begin
                    $display("%0t action_taken exp %0b got %0b", $time, e.action_taken,
                             o_out_word.action_taken);
                    errors++;
                end
            end
        end
    end

    function automatic t_row mk(logic op, logic [15:0] v, logic [19:0] g, logic [15:0] vp,
                                logic [15:0] pa, logic [15:0] ra, logic [15:0] rn, bit typed);
        t_row r;
        r.w = '{op, v, g, vp, pa, ra, rn};
        r.typed = typed;
        r.res = '0;
        return r;
    endfunction

    initial begin
        t_row rows [$];
        t_in_word w;
        cfg_shadow[CFG_ACCEL_MAX]    = 16'(RST_ACCEL_MAX);
        cfg_shadow[CFG_DECEL_MAX]    = 16'(RST_DECEL_MAX);
        cfg_shadow[CFG_HEADWAY_TIME] = 16'(RST_HEADWAY_TIME);
        cfg_shadow[CFG_LEADER_REACT] = 16'(RST_LEADER_REACT);
        cfg_shadow[CFG_ACTION_PROB]  = RST_ACTION_PROB;
        cfg_shadow[CFG_DAWDLE_SIGMA] = 16'(RST_DAWDLE_SIGMA);
        cfg_shadow[CFG_STEP_LENGTH]  = 16'(RST_STEP_LENGTH);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small gap rows give all zeros
        rows.push_back(mk(OP_STOP,   16'd500,   20'd0,       16'd0,   16'd0, 16'd0, 16'd0, 1));
        rows.push_back(mk(OP_STOP,   16'hFFFF,  20'd2,       16'hFFFF, 16'h7FFF, 16'hFFFF,
                          16'h7FFF, 1));
        rows.push_back(mk(OP_STOP,   16'd0,     20'h80000,   16'd0,   16'h8000, 16'd0,
                          16'h8000, 1));
        rows.push_back(mk(OP_FOLLOW, 16'd3000,  20'd2,       16'd0,   16'd100, 16'd0, 16'd0, 1));
        rows.push_back(mk(OP_FOLLOW, 16'hFFFF,  20'h80000,   16'd0,   16'h8000, 16'hFFFF,
                          16'hFFFF, 1));
        rows.push_back(mk(OP_FOLLOW, 16'd3000,  20'hFFFFF,   16'd0,   16'd0, 16'd0, 16'd0, 1));
        // predicted rows
        rows.push_back(mk(OP_FOLLOW, 16'd3000,  20'd0,       16'd3000, 16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd3000,  20'h80000,   16'hFFFF, 16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_STOP,   16'd0,     20'd3,       16'd0,   16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_STOP,   16'hFFFF,  20'h7FFFF,   16'd0,   16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_STOP,   16'hFFFF,  20'd100,     16'd0,   16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd0,     20'h7FFFF,   16'hFFFF, 16'h7FFF, 16'd0,
                          16'h7FFF, 0));
        rows.push_back(mk(OP_FOLLOW, 16'hFFFF,  20'd5000,    16'd0,   16'h8000, 16'hFFFF,
                          16'h8000, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd2000,  20'd20000,   16'd2500, 16'h8000, 16'd0,
                          16'h8000, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd2000,  20'd20000,   16'd2500, 16'h8000, 16'd0,
                          16'h7FFF, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd2000,  20'd20000,   16'd2500, 16'h8000, 16'hFFFF,
                          16'd0, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd2000,  20'd1000,    16'd0,   16'd0, 16'd0, 16'd0, 0));
        rows.push_back(mk(OP_FOLLOW, 16'd8000,  20'd3000,    16'd100, 16'd0, 16'd0, 16'd0, 0));
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_ACCEL_MAX, 16'd0);
                    write_reg(CFG_DECEL_MAX, 16'd1);
                    write_reg(CFG_HEADWAY_TIME, 16'd1);
                    write_reg(CFG_LEADER_REACT, 16'd0);
                    write_reg(CFG_ACTION_PROB, 16'd0);
                    write_reg(CFG_DAWDLE_SIGMA, 16'd0);
                    write_reg(CFG_STEP_LENGTH, 16'd1);
                end
                2: begin
                    write_reg(CFG_ACCEL_MAX, 16'hFFFF);
                    write_reg(CFG_DECEL_MAX, 16'hFFFF);
                    write_reg(CFG_HEADWAY_TIME, 16'hFFFF);
                    write_reg(CFG_LEADER_REACT, 16'hFFFF);
                    write_reg(CFG_ACTION_PROB, 16'hFFFF);
                    write_reg(CFG_DAWDLE_SIGMA, 16'hFFFF);
                    write_reg(CFG_STEP_LENGTH, 16'hFFFF);
                end
                3: begin
                    // zero headway and step act as one
                    write_reg(CFG_HEADWAY_TIME, 16'd0);
                    write_reg(CFG_STEP_LENGTH, 16'd0);
                    write_reg(CFG_DECEL_MAX, 16'd0);
                end
                default: begin
                    write_reg(CFG_ACCEL_MAX, 16'($urandom_range(0, 1500)));
                    write_reg(CFG_DECEL_MAX, 16'($urandom_range(1, 2500)));
                    write_reg(CFG_HEADWAY_TIME, 16'($urandom_range(1, 1024)));
                    write_reg(CFG_LEADER_REACT, 16'($urandom_range(0, 512)));
                    write_reg(CFG_ACTION_PROB, 16'($urandom));
                    write_reg(CFG_DAWDLE_SIGMA, 16'($urandom_range(0, 600)));
                    write_reg(CFG_STEP_LENGTH, 16'($urandom_range(1, 512)));
                end
            endcase
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 300; n++) begin
                if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
                if (ph == 0 && n == 150) stall_req = 1;
                w = rand_word();
                send_word(w, 0, '0);
            end
            calm = 0;
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> car_following_speed_step_core.f
rtl/cfs_pkg.sv
rtl/car_following_speed_step_core.sv
rtl/cfs_checker.sv
verif/tb.sv
